// File: design/qucnt_pkg.sv
// Package for the quad up-counter timer block: word types, operation and
// register codes, control bit positions. No dependencies.
package qucnt_pkg;

   localparam int NUM_TIMERS  = 4;
   localparam int COUNT_WIDTH = 32;
   localparam int DATA_WIDTH  = 32;
   localparam int IRQ_WIDTH   = 4;
   localparam int CTL_WIDTH   = 3;

   // control register bits
   localparam int CTL_ENABLE_BIT   = 0;
   localparam int CTL_IRQ_EN_BIT   = 1;
   localparam int CTL_PERIODIC_BIT = 2;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_TICK  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      REG_CONTROL = 2'd0,
      REG_RELOAD  = 2'd1,
      REG_COUNT   = 2'd2,
      REG_ACK     = 2'd3
   } reg_sel_type;

   typedef struct packed {
      logic [1:0]            operation;
      logic [1:0]            timer_select;
      logic [1:0]            register_select;
      logic [DATA_WIDTH-1:0] write_data;
   } req_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] read_data;
      logic [IRQ_WIDTH-1:0]  irq_lines;
   } rsp_type;

endpackage

// File: design/quad_up_counter_timer_block_core.sv
// Quad up-counter timer block: top level, request register, execute logic,
// timer state and response register. Depends on qucnt_pkg.
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+---------------------
//   req     | in        | req_valid/req_stall  | qucnt_pkg::req_type
//   rsp     | out       | rsp_valid/rsp_stall  | qucnt_pkg::rsp_type
//
// A word is held in the request register and is executed on the edge that moves
// it into the response register.
// One word per clock is sustained while rsp is not stalled; the execute step (one
// 32-bit increment and compare per timer) bounds the cycle.
// Reset (synchronous) clears all timer state and both valid flags.
// A stalled rsp holds its word; req stalls only while the request register is
// full and the response register cannot drain in the same cycle.
module quad_up_counter_timer_block_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  qucnt_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output qucnt_pkg::rsp_type rsp_data
);

   // request register
   logic               s1_valid_ff;
   qucnt_pkg::req_type s1_word_ff;

   // response register
   logic               rsp_valid_ff;
   qucnt_pkg::rsp_type rsp_word_ff;
   qucnt_pkg::rsp_type rsp_word_in;

   // timer state
   logic [qucnt_pkg::CTL_WIDTH-1:0]   ctl_ff    [qucnt_pkg::NUM_TIMERS];
   logic [qucnt_pkg::CTL_WIDTH-1:0]   ctl_in    [qucnt_pkg::NUM_TIMERS];
   logic [qucnt_pkg::COUNT_WIDTH-1:0] reload_ff [qucnt_pkg::NUM_TIMERS];
   logic [qucnt_pkg::COUNT_WIDTH-1:0] reload_in [qucnt_pkg::NUM_TIMERS];
   logic [qucnt_pkg::COUNT_WIDTH-1:0] count_ff  [qucnt_pkg::NUM_TIMERS];
   logic [qucnt_pkg::COUNT_WIDTH-1:0] count_in  [qucnt_pkg::NUM_TIMERS];
   logic [qucnt_pkg::NUM_TIMERS-1:0]  pend_ff;
   logic [qucnt_pkg::NUM_TIMERS-1:0]  pend_in;

   logic out_ready;
   logic s1_fire;

   // The response register can take a word when it is empty or draining now.
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && out_ready;
   assign req_stall = s1_valid_ff && !out_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

   // Request register: refill whenever the held word moves on or it is empty.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         s1_word_ff <= req_data;
      end
   end

   // Execute: one read, one write or one tick of all timers; the unused code changes nothing.
   always_comb begin
      ctl_in      = ctl_ff;
      reload_in   = reload_ff;
      count_in    = count_ff;
      pend_in     = pend_ff;
      rsp_word_in = '0;

      unique case (s1_word_ff.operation)
         qucnt_pkg::OP_READ: begin
            unique case (s1_word_ff.register_select)
               qucnt_pkg::REG_CONTROL: begin
                  rsp_word_in.read_data = {
                     {(qucnt_pkg::DATA_WIDTH-qucnt_pkg::CTL_WIDTH){1'b0}},
                     ctl_ff[s1_word_ff.timer_select]};
               end
               qucnt_pkg::REG_RELOAD: begin
                  rsp_word_in.read_data = reload_ff[s1_word_ff.timer_select];
               end
               qucnt_pkg::REG_COUNT: begin
                  rsp_word_in.read_data = count_ff[s1_word_ff.timer_select];
               end
               qucnt_pkg::REG_ACK: begin
                  rsp_word_in.read_data = {{(qucnt_pkg::DATA_WIDTH-1){1'b0}},
                                           pend_ff[s1_word_ff.timer_select]};
               end
               default: ;
            endcase
         end
         qucnt_pkg::OP_WRITE: begin
            unique case (s1_word_ff.register_select)
               qucnt_pkg::REG_CONTROL: begin
                  // reserved bits drop here
                  ctl_in[s1_word_ff.timer_select] =
                     s1_word_ff.write_data[qucnt_pkg::CTL_WIDTH-1:0];
               end
               qucnt_pkg::REG_RELOAD: begin
                  // reload also loads the count
                  reload_in[s1_word_ff.timer_select] = s1_word_ff.write_data;
                  count_in[s1_word_ff.timer_select]  = s1_word_ff.write_data;
               end
               qucnt_pkg::REG_COUNT: begin
                  count_in[s1_word_ff.timer_select] = s1_word_ff.write_data;
               end
               qucnt_pkg::REG_ACK: begin
                  // only a zero write acknowledges
                  if (s1_word_ff.write_data == '0) begin
                     pend_in[s1_word_ff.timer_select] = 1'b0;
                  end
               end
               default: ;
            endcase
         end
         qucnt_pkg::OP_TICK: begin
            // advance every enabled timer in parallel
            for (int t = 0; t < qucnt_pkg::NUM_TIMERS; t++) begin
               if (ctl_ff[t][qucnt_pkg::CTL_ENABLE_BIT]) begin
                  if (count_ff[t] == qucnt_pkg::COUNT_MAX) begin
                     if (ctl_ff[t][qucnt_pkg::CTL_PERIODIC_BIT]) begin
                        count_in[t] = reload_ff[t];
                     end else begin
                        // one-shot: wrap and stop
                        count_in[t] = '0;
                        ctl_in[t][qucnt_pkg::CTL_ENABLE_BIT] = 1'b0;
                     end
                     if (ctl_ff[t][qucnt_pkg::CTL_IRQ_EN_BIT]) begin
                        pend_in[t] = 1'b1;
                     end
                  end else begin
                     count_in[t] = count_ff[t] +
                                   {{(qucnt_pkg::COUNT_WIDTH-1){1'b0}}, 1'b1};
                  end
               end
            end
         end
         default: ;
      endcase

      rsp_word_in.irq_lines = pend_in;
   end

   // Timer state commits when the word executes.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < qucnt_pkg::NUM_TIMERS; t++) begin
            ctl_ff[t]    <= '0;
            reload_ff[t] <= '0;
            count_ff[t]  <= '0;
         end
         pend_ff <= '0;
      end else if (s1_fire) begin
         ctl_ff    <= ctl_in;
         reload_ff <= reload_in;
         count_ff  <= count_in;
         pend_ff   <= pend_in;
      end
   end

   // Response register: hold while stalled, load the executed word.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
      if (s1_fire) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   // Only a tick can raise a pending flag.
   assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_word_ff.operation != qucnt_pkg::OP_TICK)
      |=> ((pend_ff & ~$past(pend_ff)) == '0))
      else $error("pending flag rose without a tick");

   // A write returns zero data.
   assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_word_ff.operation == qucnt_pkg::OP_WRITE)
      |=> (rsp_word_ff.read_data == '0))
      else $error("write returned nonzero read data");

   // The interrupt lines of a fresh response match the committed flags.
   assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> (rsp_word_ff.irq_lines == pend_ff))
      else $error("irq lines differ from pending flags");

   // req stalls only while both the request and response registers are full.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("req stalled with room to accept");

endmodule

// File: tb/testbench.sv
// Self-checking bench for quad_up_counter_timer_block_core: register access,
// counter ticks, rollovers and interrupt lines against an in-bench timer model.
// Depends on qucnt_pkg and the block's top level.
module testbench;

   typedef logic [qucnt_pkg::DATA_WIDTH-1:0]  data_type;
   typedef logic [qucnt_pkg::COUNT_WIDTH-1:0] count_type;

   // Operation code that the block must ignore
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Control register write values
   localparam data_type CTL_EN  = data_type'(1) << qucnt_pkg::CTL_ENABLE_BIT;
   localparam data_type CTL_IRQ = data_type'(1) << qucnt_pkg::CTL_IRQ_EN_BIT;
   localparam data_type CTL_PER = data_type'(1) << qucnt_pkg::CTL_PERIODIC_BIT;

   localparam int STALL_LIMIT  = 1000;  // cycles with no handshake before giving up
   localparam int DRAIN_CYCLES = 10;    // margin after the last response
   localparam int MAX_REPORTS  = 10;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   qucnt_pkg::req_type req_data  = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   qucnt_pkg::rsp_type rsp_data;

   quad_up_counter_timer_block_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Timer model: mirror of the block's state, updated on each accepted word
   // ------------------------------------------------------------------
   logic [qucnt_pkg::CTL_WIDTH-1:0] tmr_ctl    [qucnt_pkg::NUM_TIMERS];
   count_type                       tmr_reload [qucnt_pkg::NUM_TIMERS];
   count_type                       tmr_count  [qucnt_pkg::NUM_TIMERS];
   logic                            tmr_pend   [qucnt_pkg::NUM_TIMERS];

   qucnt_pkg::rsp_type timer_rsp_q [$];   // responses still owed, oldest first

   int words_sent   = 0;
   int ticks_sent   = 0;
   int rollovers    = 0;
   int rsp_checked  = 0;
   int errors       = 0;

   int gap_pct      = 0;       // chance of a sender gap after each word
   int stall_pct    = 0;       // chance of starting a receiver stall each cycle
   int stall_left   = 0;
   int quiet_cycles = 0;

   function automatic void clear_timers();
      int i;
      for (i = 0; i < qucnt_pkg::NUM_TIMERS; i++) begin
         tmr_ctl[i]    = '0;
         tmr_reload[i] = '0;
         tmr_count[i]  = '0;
         tmr_pend[i]   = 1'b0;
      end
   endfunction

   // Apply one word to the model and return the response it must produce
   function automatic qucnt_pkg::rsp_type timer_step(qucnt_pkg::req_type w);
      qucnt_pkg::rsp_type r;
      int                 t;
      int                 i;
      t           = w.timer_select;
      r.read_data = '0;
      r.irq_lines = '0;
      case (w.operation)
         qucnt_pkg::OP_READ: begin
            case (w.register_select)
               qucnt_pkg::REG_CONTROL: r.read_data = data_type'(tmr_ctl[t]);
               qucnt_pkg::REG_RELOAD:  r.read_data = data_type'(tmr_reload[t]);
               qucnt_pkg::REG_COUNT:   r.read_data = data_type'(tmr_count[t]);
               qucnt_pkg::REG_ACK:     r.read_data = data_type'(tmr_pend[t]);
               default:                r.read_data = '0;
            endcase
         end
         qucnt_pkg::OP_WRITE: begin
            case (w.register_select)
               qucnt_pkg::REG_CONTROL:
                  tmr_ctl[t] = w.write_data[qucnt_pkg::CTL_WIDTH-1:0];
               qucnt_pkg::REG_RELOAD: begin
                  tmr_reload[t] = count_type'(w.write_data);
                  tmr_count[t]  = count_type'(w.write_data);
               end
               qucnt_pkg::REG_COUNT: tmr_count[t] = count_type'(w.write_data);
               qucnt_pkg::REG_ACK:   if (w.write_data == '0) tmr_pend[t] = 1'b0;
               default: ;
            endcase
         end
         qucnt_pkg::OP_TICK: begin
            for (i = 0; i < qucnt_pkg::NUM_TIMERS; i++) begin
               if (tmr_ctl[i][qucnt_pkg::CTL_ENABLE_BIT]) begin
                  if (tmr_count[i] == qucnt_pkg::COUNT_MAX) begin
                     rollovers++;
                     if (tmr_ctl[i][qucnt_pkg::CTL_PERIODIC_BIT]) begin
                        tmr_count[i] = tmr_reload[i];
                     end else begin
                        tmr_count[i]                          = '0;
                        tmr_ctl[i][qucnt_pkg::CTL_ENABLE_BIT] = 1'b0;
                     end
                     if (tmr_ctl[i][qucnt_pkg::CTL_IRQ_EN_BIT]) tmr_pend[i] = 1'b1;
                  end else begin
                     tmr_count[i] = tmr_count[i] + count_type'(1);
                  end
               end
            end
         end
         default: ;   // unused code: no state change
      endcase
      for (i = 0; i < qucnt_pkg::NUM_TIMERS && i < qucnt_pkg::IRQ_WIDTH; i++)
         r.irq_lines[i] = tmr_pend[i];
      return r;
   endfunction

   function automatic qucnt_pkg::req_type make_word(logic [1:0] op, int t,
                                                    logic [1:0] rs, data_type d);
      qucnt_pkg::req_type w;
      w.operation       = op;
      w.timer_select    = 2'(t);
      w.register_select = rs;
      w.write_data      = d;
      return w;
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int gap_len();
      if ($urandom_range(9) == 0) return $urandom_range(40, 12);
      return $urandom_range(3, 1);
   endfunction

   // Random word, biased so that counters sit near the top and roll over often
   function automatic qucnt_pkg::req_type random_word();
      qucnt_pkg::req_type w;
      int                 pick;
      w.timer_select    = 2'($urandom_range(3));
      w.register_select = 2'($urandom_range(3));
      w.write_data      = $urandom();
      pick = $urandom_range(99);
      if (pick < 35)      w.operation = qucnt_pkg::OP_TICK;
      else if (pick < 65) w.operation = qucnt_pkg::OP_READ;
      else if (pick < 95) w.operation = qucnt_pkg::OP_WRITE;
      else                w.operation = OP_UNUSED;
      if (w.operation == qucnt_pkg::OP_WRITE) begin
         case (w.register_select)
            qucnt_pkg::REG_CONTROL:
               if ($urandom_range(3) != 0)
                  w.write_data[qucnt_pkg::CTL_ENABLE_BIT] = 1'b1;
            qucnt_pkg::REG_RELOAD, qucnt_pkg::REG_COUNT:
               if ($urandom_range(9) < 7)
                  w.write_data = qucnt_pkg::COUNT_MAX - $urandom_range(6);
            qucnt_pkg::REG_ACK:
               if ($urandom_range(9) < 6) w.write_data = '0;
            default: ;
         endcase
      end
      return w;
   endfunction

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // Drop valid and scramble the payload while the sender idles
   task automatic idle_sender(input int n);
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
         req_data  <= random_word();
      end
   endtask

   // Present one word and hold it until accepted; leave valid high on return unless a sender gap follows
   task automatic send_word(input qucnt_pkg::req_type w);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      timer_rsp_q.push_back(timer_step(w));
      words_sent++;
      if (w.operation == qucnt_pkg::OP_TICK) ticks_sent++;
      if (gap_pct > 0 && $urandom_range(99) < gap_pct) idle_sender(gap_len());
   endtask

   // Hold off the sender until every owed response has arrived
   task automatic wait_drained();
      idle_sender(1);
      while (timer_rsp_q.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Response side: random stall and checker
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (stall_left == 0 && stall_pct > 0 && $urandom_range(99) < stall_pct)
         stall_left = gap_len();
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      qucnt_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (timer_rsp_q.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("unexpected response: read_data=%h irq_lines=%b",
                        rsp_data.read_data, rsp_data.irq_lines);
         end else begin
            want = timer_rsp_q.pop_front();
            rsp_checked++;
            if (rsp_data.read_data !== want.read_data) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("response %0d read_data: expected %h, got %h",
                           rsp_checked, want.read_data, rsp_data.read_data);
            end
            if (rsp_data.irq_lines !== want.irq_lines) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("response %0d irq_lines: expected %b, got %b",
                           rsp_checked, want.irq_lines, rsp_data.irq_lines);
            end
         end
      end
   end

   // Watchdog: give up when no handshake happens for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("no handshake for %0d cycles, %0d responses outstanding",
                     quiet_cycles, timer_rsp_q.size());
            $display("[quad_up_counter_timer_block_core] ERROR");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Registers read zero after reset
   task automatic test_reset_values();
      send_word(make_word(qucnt_pkg::OP_READ, 0, qucnt_pkg::REG_CONTROL, '1));
      send_word(make_word(qucnt_pkg::OP_READ, 3, qucnt_pkg::REG_COUNT, '0));
      send_word(make_word(qucnt_pkg::OP_READ, 2, qucnt_pkg::REG_ACK, '0));
      send_word(make_word(qucnt_pkg::OP_READ, 1, qucnt_pkg::REG_RELOAD, '0));
   endtask

   // Reserved control bits, reload loading the count, count write
   task automatic test_register_access();
      send_word(make_word(qucnt_pkg::OP_WRITE, 1, qucnt_pkg::REG_CONTROL,
                          32'hFFFF_FFF8));
      send_word(make_word(qucnt_pkg::OP_READ, 1, qucnt_pkg::REG_CONTROL, '0));
      send_word(make_word(qucnt_pkg::OP_WRITE, 1, qucnt_pkg::REG_RELOAD,
                          32'h0000_0010));
      send_word(make_word(qucnt_pkg::OP_READ, 1, qucnt_pkg::REG_COUNT, '0));
      send_word(make_word(qucnt_pkg::OP_WRITE, 1, qucnt_pkg::REG_COUNT,
                          qucnt_pkg::COUNT_MAX));
      send_word(make_word(qucnt_pkg::OP_WRITE, 1, qucnt_pkg::REG_CONTROL,
                          CTL_EN | CTL_PER));
      send_word(make_word(qucnt_pkg::OP_READ, 1, qucnt_pkg::REG_RELOAD, '0));
   endtask

   // One-shot rollover with interrupt, periodic rollover with and without it,
   // disabled timer holding still
   task automatic test_rollover();
      send_word(make_word(qucnt_pkg::OP_WRITE, 0, qucnt_pkg::REG_RELOAD,
                          qucnt_pkg::COUNT_MAX - 1));
      send_word(make_word(qucnt_pkg::OP_WRITE, 0, qucnt_pkg::REG_CONTROL, ~CTL_PER));
      send_word(make_word(qucnt_pkg::OP_WRITE, 3, qucnt_pkg::REG_RELOAD,
                          32'h1234_5678));
      send_word(make_word(qucnt_pkg::OP_WRITE, 3, qucnt_pkg::REG_COUNT,
                          qucnt_pkg::COUNT_MAX));
      send_word(make_word(qucnt_pkg::OP_WRITE, 3, qucnt_pkg::REG_CONTROL,
                          CTL_EN | CTL_IRQ | CTL_PER));
      send_word(make_word(qucnt_pkg::OP_TICK, 3, qucnt_pkg::REG_ACK, '1));
      send_word(make_word(qucnt_pkg::OP_TICK, 0, qucnt_pkg::REG_CONTROL, '0));
      send_word(make_word(qucnt_pkg::OP_READ, 0, qucnt_pkg::REG_CONTROL, '0));
      send_word(make_word(qucnt_pkg::OP_READ, 3, qucnt_pkg::REG_COUNT, '0));
      send_word(make_word(qucnt_pkg::OP_READ, 2, qucnt_pkg::REG_COUNT, '0));
   endtask

   // Nonzero acknowledge is ignored, zero clears the flag
   task automatic test_acknowledge();
      send_word(make_word(qucnt_pkg::OP_READ, 0, qucnt_pkg::REG_ACK, '0));
      send_word(make_word(qucnt_pkg::OP_WRITE, 0, qucnt_pkg::REG_ACK,
                          32'h0000_0010));
      send_word(make_word(qucnt_pkg::OP_WRITE, 3, qucnt_pkg::REG_ACK, '0));
      send_word(make_word(qucnt_pkg::OP_READ, 3, qucnt_pkg::REG_ACK, '0));
   endtask

   // Unused operation code: no effect, zero data
   task automatic test_unused_op();
      send_word(make_word(OP_UNUSED, 3, qucnt_pkg::REG_ACK, '1));
      send_word(make_word(qucnt_pkg::OP_READ, 0, qucnt_pkg::REG_ACK, '0));
   endtask

   task automatic test_random_traffic(input int n, input int gap, input int stall);
      gap_pct   = gap;
      stall_pct = stall;
      repeat (n) send_word(random_word());
   endtask

   initial begin
      clear_timers();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_register_access();
      test_rollover();
      test_acknowledge();
      test_unused_op();

      // back-to-back words with the receiver always ready
      test_random_traffic(120, 0, 0);
      // moderate idling on both sides
      test_random_traffic(180, 20, 25);
      // let the pipeline empty out before heavy traffic
      wait_drained();
      test_random_traffic(150, 50, 50);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d words (%0d ticks, %0d counter rollovers), checked %0d responses",
               words_sent, ticks_sent, rollovers, rsp_checked);
      if (errors == 0 && timer_rsp_q.size() == 0) begin
         $display("[quad_up_counter_timer_block_core] OK");
      end else begin
         $display("%0d mismatches, %0d responses missing", errors, timer_rsp_q.size());
         $display("[quad_up_counter_timer_block_core] ERROR");
      end
      $finish;
   end

endmodule
